FILE: rtl/box_overlap_ratio_assert.svh
// ---------------------------------------------------------------------------
// box_overlap_ratio assertion macros
// Concurrent checks on clk_i / rst_ni; they compile away when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_RATIO_ASSERT_SVH
`define BOX_OVERLAP_RATIO_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset
`define BOR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included
`define BOR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define BOR_ASSERT(lbl, prop, msg)
`define BOR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/bor_pkg.sv
// ---------------------------------------------------------------------------
// bor_pkg
// Shared payload types and constants of the box overlap ratio block.
// ---------------------------------------------------------------------------
`default_nettype none

package bor_pkg;

  // Port field widths
  localparam int unsigned FieldW   = 16;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RatioW   = FracBits + 1;

  // 1.0 in Q1.16
  localparam logic [RatioW-1:0] RatioOne = RatioW'(1) << FracBits;

  typedef struct packed {
    logic [FieldW-1:0] a_x;
    logic [FieldW-1:0] a_y;
    logic [FieldW-1:0] a_w;
    logic [FieldW-1:0] a_h;
    logic [FieldW-1:0] b_x;
    logic [FieldW-1:0] b_y;
    logic [FieldW-1:0] b_w;
    logic [FieldW-1:0] b_h;
  } box_pair_t;

  typedef struct packed {
    logic [RatioW-1:0] ratio;
    logic              degenerate;
  } ratio_t;

  // Special-case flags carried alongside the divider
  typedef struct packed {
    logic full;        // intersection equals union
    logic degenerate;  // union is zero
  } ratio_flags_t;

endpackage

`default_nettype wire

FILE: rtl/bor_geom.sv
// ---------------------------------------------------------------------------
// bor_geom
// Three-stage front end: overlap spans, areas, union and special-case flags.
// ---------------------------------------------------------------------------
`default_nettype none

module bor_geom #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire bor_pkg::box_pair_t        data_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output logic [2*CoordBits-1:0]         inter_o,
  output logic [2*CoordBits:0]           union_o,
  output bor_pkg::ratio_flags_t          flags_o
);

  localparam int unsigned AreaW  = 2 * CoordBits;
  localparam int unsigned UnionW = AreaW + 1;

  logic [2:0] v_q;
  logic [2:0] en;

  // stage load enables, back to front
  assign en[2]   = !v_q[2] || ready_i;
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];
  assign valid_o = v_q[2];

  // ---- stage 1: spans ----
  logic [CoordBits-1:0] p   [2];
  logic [CoordBits-1:0] pl  [2];
  logic [CoordBits-1:0] q   [2];
  logic [CoordBits-1:0] ql  [2];
  logic [CoordBits-1:0] ovl [2];

  assign p[0]  = CoordBits'(data_i.a_x);
  assign pl[0] = CoordBits'(data_i.a_w);
  assign q[0]  = CoordBits'(data_i.b_x);
  assign ql[0] = CoordBits'(data_i.b_w);
  assign p[1]  = CoordBits'(data_i.a_y);
  assign pl[1] = CoordBits'(data_i.a_h);
  assign q[1]  = CoordBits'(data_i.b_y);
  assign ql[1] = CoordBits'(data_i.b_h);

  always_comb begin
    logic [CoordBits:0] pe, qe, pz, qz, lo, hi, diff;
    logic               sep;
    for (int i = 0; i < 2; i++) begin
      pz   = {1'b0, p[i]};
      qz   = {1'b0, q[i]};
      pe   = pz + {1'b0, pl[i]};
      qe   = qz + {1'b0, ql[i]};
      sep  = (pz > qe) || (qz > pe);
      lo   = (pz > qz) ? pz : qz;
      hi   = (pe < qe) ? pe : qe;
      diff = hi - lo;
      // overlap never exceeds the shorter length, so it fits CoordBits
      ovl[i] = sep ? '0 : diff[CoordBits-1:0];
    end
  end

  logic [CoordBits-1:0] s1_ix_q, s1_iy_q, s1_aw_q, s1_ah_q, s1_bw_q, s1_bh_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_ix_q <= ovl[0];
      s1_iy_q <= ovl[1];
      s1_aw_q <= pl[0];
      s1_ah_q <= pl[1];
      s1_bw_q <= ql[0];
      s1_bh_q <= ql[1];
    end
  end

  // ---- stage 2: products ----
  logic [AreaW-1:0] s2_inter_q, s2_area_a_q, s2_area_b_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_inter_q  <= AreaW'(s1_ix_q) * AreaW'(s1_iy_q);
      s2_area_a_q <= AreaW'(s1_aw_q) * AreaW'(s1_ah_q);
      s2_area_b_q <= AreaW'(s1_bw_q) * AreaW'(s1_bh_q);
    end
  end

  // ---- stage 3: union and flags ----
  // inter <= min(area_a, area_b), so both comparisons are exact tests
  logic [AreaW-1:0]      s3_inter_q;
  logic [UnionW-1:0]     s3_union_q;
  bor_pkg::ratio_flags_t s3_flags_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_inter_q            <= s2_inter_q;
      s3_union_q            <= UnionW'(s2_area_a_q) + UnionW'(s2_area_b_q)
                               - UnionW'(s2_inter_q);
      s3_flags_q.full       <= (s2_area_a_q == s2_inter_q) && (s2_area_b_q == s2_inter_q);
      s3_flags_q.degenerate <= (s2_area_a_q == '0) && (s2_area_b_q == '0);
    end
  end

  assign inter_o = s3_inter_q;
  assign union_o = s3_union_q;
  assign flags_o = s3_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bor_div.sv
// ---------------------------------------------------------------------------
// bor_div
// Pipelined restoring divider, one quotient bit per stage, plus result select.
// ---------------------------------------------------------------------------
`default_nettype none

module bor_div #(
  parameter int unsigned CoordBits = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           ready_o,
  input  wire logic [2*CoordBits-1:0]    inter_i,
  input  wire logic [2*CoordBits:0]      union_i,
  input  wire bor_pkg::ratio_flags_t     flags_i,
  output logic                           valid_o,
  input  wire logic                      ready_i,
  output bor_pkg::ratio_t                data_o
);

  localparam int unsigned UnionW = 2 * CoordBits + 1;
  localparam int unsigned Steps  = bor_pkg::FracBits;

  logic [Steps-1:0] v_q;
  logic [Steps-1:0] en;

  // per-stage inputs
  logic [UnionW-1:0]            rem_in   [Steps];
  logic [UnionW-1:0]            uni_in   [Steps];
  logic [Steps-1:0]             quo_in   [Steps];
  bor_pkg::ratio_flags_t        flags_in [Steps];
  logic                         v_in     [Steps];

  // stage registers; remainder and divisor are dropped after the last step
  logic [UnionW-1:0]            rem_q    [Steps-1];
  logic [UnionW-1:0]            uni_q    [Steps-1];
  logic [Steps-1:0]             quo_q    [Steps];
  bor_pkg::ratio_flags_t        flags_q  [Steps];

  assign rem_in[0]   = UnionW'(inter_i);
  assign uni_in[0]   = union_i;
  assign quo_in[0]   = '0;
  assign flags_in[0] = flags_i;
  assign v_in[0]     = valid_i;

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [UnionW:0]   rem2;
    logic              ge;

    assign rem2   = {rem_in[k], 1'b0};
    assign ge     = rem2 >= {1'b0, uni_in[k]};

    if (k == Steps - 1) begin : g_last
      assign en[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      logic [UnionW-1:0] rem_nx;

      assign rem_nx = ge ? UnionW'(rem2 - {1'b0, uni_in[k]}) : rem2[UnionW-1:0];
      assign en[k]  = !v_q[k] || en[k+1];

      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          rem_q[k] <= rem_nx;
          uni_q[k] <= uni_in[k];
        end
      end

      assign rem_in[k+1]   = rem_q[k];
      assign uni_in[k+1]   = uni_q[k];
      assign quo_in[k+1]   = quo_q[k];
      assign flags_in[k+1] = flags_q[k];
      assign v_in[k+1]     = v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        quo_q[k]   <= {quo_in[k][Steps-2:0], ge};
        flags_q[k] <= flags_in[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_in[k];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[Steps-1];

  always_comb begin
    data_o.degenerate = flags_q[Steps-1].degenerate;
    if (flags_q[Steps-1].degenerate) begin
      data_o.ratio = '0;
    end else if (flags_q[Steps-1].full) begin
      data_o.ratio = bor_pkg::RatioOne;
    end else begin
      data_o.ratio = {1'b0, quo_q[Steps-1]};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/box_overlap_ratio.sv
// ---------------------------------------------------------------------------
// box_overlap_ratio: IoU of two axis-aligned boxes, Q1.16. 3 geometry stages
// + 16 divider stages, one quotient bit each; throughput one transaction per
// cycle while out_ready_i is not held low. Reset clears only the pipeline valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

`include "box_overlap_ratio_assert.svh"

module box_overlap_ratio #(
  // Working width of coordinates and sizes; field bits above it are ignored
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire bor_pkg::box_pair_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output bor_pkg::ratio_t           out_data_o
);

  // Datapath overview
  //   geom stage 1 : box edges (x + w), strict separation test, overlap span
  //   geom stage 2 : three multipliers -> intersection, area A, area B
  //   geom stage 3 : union = A + B - I, flags for I == U and U == 0
  //   div stages   : restoring division I / U, one fraction bit per stage
  // Every stage has its own valid bit and loads when it is empty or when the
  // stage after it loads, so bubbles collapse and a stall at the output only
  // backs up as far as the pipeline is full. The last divider stage doubles
  // as the output register.

  localparam int unsigned AreaW  = 2 * COORD_BITS;
  localparam int unsigned UnionW = AreaW + 1;

  logic                  geom_valid;
  logic                  div_ready;
  logic [AreaW-1:0]      geom_inter;
  logic [UnionW-1:0]     geom_union;
  bor_pkg::ratio_flags_t geom_flags;

  bor_geom #(
    .CoordBits (COORD_BITS)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (geom_valid),
    .ready_i (div_ready),
    .inter_o (geom_inter),
    .union_o (geom_union),
    .flags_o (geom_flags)
  );

  // Intersection never exceeds the union, so the quotient stays below 1.0
  // except when they are equal; that case is flagged and forced to 1.0.
  bor_div #(
    .CoordBits (COORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (geom_valid),
    .ready_o (div_ready),
    .inter_i (geom_inter),
    .union_i (geom_union),
    .flags_i (geom_flags),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // A zero union always yields a zero ratio
  `BOR_ASSERT(a_degenerate_zero, out_valid_o && out_data_o.degenerate |-> out_data_o.ratio == '0, "degenerate result with nonzero ratio")

  // Output taking a transaction must open the whole load-enable chain
  `BOR_ASSERT(a_ready_chain, out_ready_i |-> in_ready_o, "input stalled while output drains")

  // Reset empties the pipeline
  `BOR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid right after reset")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: box_overlap_ratio testbench
// Streams box pairs through the IoU block under random source gaps and sink
// stalls, predicts each ratio and degenerate flag in a scoreboard and checks
// every result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef bor_pkg::box_pair_t box_pair_t;
  typedef bor_pkg::ratio_t    ratio_t;

  localparam int unsigned FieldW   = bor_pkg::FieldW;
  localparam int unsigned FracBits = bor_pkg::FracBits;
  localparam int unsigned RatioW   = bor_pkg::RatioW;

  // Working coordinate width; matches the block's default parameter.
  localparam int unsigned CoordBits    = 16;
  localparam int unsigned RandomPairs  = 950;
  // Pipeline is 19 deep; the settle wait gives stray outputs time to flush.
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 100;

  // --------------------------------------------------------------------------
  // Scoreboard: turns each accepted box pair into its expected ratio and
  // compares result transactions against the oldest one still outstanding.
  // --------------------------------------------------------------------------
  class iou_scoreboard;
    ratio_t      expected_q[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // Overlap length of [lo_a, lo_a + len_a] and [lo_b, lo_b + len_b].
    // Strict greater-than: shared edges give a zero-length overlap, not a gap.
    function longint unsigned span_len(longint unsigned lo_a, longint unsigned len_a,
                                       longint unsigned lo_b, longint unsigned len_b);
      longint unsigned end_a, end_b, lo, hi;
      end_a = lo_a + len_a;
      end_b = lo_b + len_b;
      if (lo_a > end_b || lo_b > end_a) return 0;
      lo = (lo_a > lo_b) ? lo_a : lo_b;
      hi = (end_a < end_b) ? end_a : end_b;
      return hi - lo;
    endfunction

    // Exact IoU in 64-bit math: the union can reach 33 bits, and
    // inter << 16 stays below 2^48, so nothing wraps.
    function ratio_t iou_of(box_pair_t p);
      longint unsigned mask, iw, ih, inter, area_a, area_b, union_area, quo;
      ratio_t r;
      mask = (64'd1 << CoordBits) - 1;
      iw = span_len(p.a_x & mask, p.a_w & mask, p.b_x & mask, p.b_w & mask);
      ih = span_len(p.a_y & mask, p.a_h & mask, p.b_y & mask, p.b_h & mask);
      inter  = iw * ih;
      area_a = (p.a_w & mask) * (p.a_h & mask);
      area_b = (p.b_w & mask) * (p.b_h & mask);
      union_area = area_a + area_b - inter;
      r = '0;
      if (union_area == 0) begin
        r.degenerate = 1'b1;
      end else begin
        // inter never exceeds the union, so this tops out at exactly 1.0
        quo = (inter << FracBits) / union_area;
        r.ratio = quo[RatioW-1:0];
      end
      return r;
    endfunction

    task report_mismatch(string what);
      fails++;
      if (fails <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void note_pair(box_pair_t p);
      expected_q.insert(expected_q.size(), iou_of(p));
    endfunction

    task check_ratio(ratio_t got);
      ratio_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result ratio=%0d degenerate=%0b",
                                  got.ratio, got.degenerate));
      end else begin
        want = expected_q.pop_front();
        if (got.ratio !== want.ratio)
          report_mismatch($sformatf("ratio got %0d want %0d", got.ratio, want.ratio));
        if (got.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate got %0b want %0b",
                                    got.degenerate, want.degenerate));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs; every input has a known value at time 0.
  // --------------------------------------------------------------------------
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  box_pair_t in_data_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  ratio_t    out_data_o;

  iou_scoreboard sb;

  // When set, both sides run flat out: no source gaps, no sink stalls.
  bit quiet = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  box_overlap_ratio uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Idle length: mostly none, often a few cycles, now and then a long hole.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sampled right after the edge, so it sees the values the block
  // saw. Inputs are noted before outputs are checked at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_pair(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_ratio(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: after each ready cycle it may start a stall of random length,
  // so stalls land on any pipeline phase.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
      @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // Present one pair, hold it until the transaction completes, then maybe idle.
  // Valid is only dropped when a gap follows, so back-to-back pairs keep it high.
  task automatic send_pair(box_pair_t p);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_boxes(input logic [FieldW-1:0] ax, ay, aw, ah, bx, by, bw, bh);
    send_pair('{a_x: ax, a_y: ay, a_w: aw, a_h: ah, b_x: bx, b_y: by, b_w: bw, b_h: bh});
  endtask

  // Hold off the source until every outstanding ratio has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Random pair drawn from a mix of shapes. Plain random pairs almost never
  // overlap, so most draws are built to overlap, nest, coincide or touch.
  function automatic box_pair_t make_pair();
    box_pair_t   p;
    int unsigned kind, base_x, base_y;
    kind = $urandom_range(0, 99);
    p = {$urandom, $urandom, $urandom, $urandom};
    base_x = $urandom_range(0, 65535 - 400);
    base_y = $urandom_range(0, 65535 - 400);
    if (kind < 20) begin
      // fully random: every field bit toggles, mostly separated boxes
    end else if (kind < 55 || (kind >= 75 && kind < 85)) begin
      // clustered small boxes around a common point
      p.a_x = FieldW'(base_x + $urandom_range(0, 64));
      p.a_y = FieldW'(base_y + $urandom_range(0, 64));
      p.b_x = FieldW'(base_x + $urandom_range(0, 64));
      p.b_y = FieldW'(base_y + $urandom_range(0, 64));
      p.a_w = FieldW'($urandom_range(0, 160));
      p.a_h = FieldW'($urandom_range(0, 160));
      p.b_w = FieldW'($urandom_range(0, 160));
      p.b_h = FieldW'($urandom_range(0, 160));
      if (kind >= 75) begin
        // collapse some sizes to zero: lines, points, zero unions
        if ($urandom_range(0, 1)) p.a_w = '0;
        if ($urandom_range(0, 1)) p.a_h = '0;
        if ($urandom_range(0, 1)) p.b_w = '0;
        if ($urandom_range(0, 1)) p.b_h = '0;
      end
    end else if (kind < 65) begin
      // same box, or off by one pixel somewhere: ratio at or near one
      p.b_x = p.a_x;
      p.b_y = p.a_y;
      p.b_w = p.a_w;
      p.b_h = p.a_h;
      case ($urandom_range(0, 3))
        1:       p.b_x = p.a_x ^ FieldW'(1);
        2:       p.b_w = p.a_w ^ FieldW'(1);
        3:       p.b_h = p.a_h ^ FieldW'(1);
        default: ;
      endcase
    end else if (kind < 75) begin
      // B nested inside A
      p.a_x = FieldW'($urandom_range(0, 32767));
      p.a_y = FieldW'($urandom_range(0, 32767));
      p.a_w = FieldW'($urandom_range(0, 32768));
      p.a_h = FieldW'($urandom_range(0, 32768));
      p.b_x = FieldW'(p.a_x + $urandom_range(0, p.a_w));
      p.b_y = FieldW'(p.a_y + $urandom_range(0, p.a_h));
      p.b_w = FieldW'($urandom_range(0, p.a_x + p.a_w - p.b_x));
      p.b_h = FieldW'($urandom_range(0, p.a_y + p.a_h - p.b_y));
    end else if (kind < 95) begin
      // huge boxes: 33-bit unions and edges past the coordinate range
      p.a_w = FieldW'(65535 - $urandom_range(0, 255));
      p.a_h = FieldW'(65535 - $urandom_range(0, 255));
      p.b_w = FieldW'(65535 - $urandom_range(0, 255));
      p.b_h = FieldW'(65535 - $urandom_range(0, 255));
      p.a_x = FieldW'($urandom_range(0, 1) ? $urandom_range(0, 255) : p.a_x);
      p.a_y = FieldW'($urandom_range(0, 1) ? $urandom_range(0, 255) : p.a_y);
    end else begin
      // B starts exactly where A ends, on one axis; the other axis overlaps
      p.a_x = FieldW'($urandom_range(0, 32767));
      p.a_y = FieldW'($urandom_range(0, 32767));
      p.a_w = FieldW'($urandom_range(0, 32767));
      p.a_h = FieldW'($urandom_range(0, 32767));
      p.b_w = FieldW'($urandom_range(0, 32767));
      p.b_h = FieldW'($urandom_range(0, 32767));
      if ($urandom_range(0, 1)) begin
        p.b_x = p.a_x + p.a_w;
        p.b_y = p.a_y;
      end else begin
        p.b_x = p.a_x;
        p.b_y = p.a_y + p.a_h;
      end
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed corners, a full drain, random pairs with a
  // second drain halfway, then flush and verdict.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero: both areas zero, degenerate
    send_boxes(0, 0, 0, 0, 0, 0, 0, 0);
    // all fields at max: identical huge boxes, ratio exactly one
    send_boxes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_boxes(10, 10, 20, 20, 10, 10, 20, 20);
    // separated on x, separated on y
    send_boxes(0, 0, 10, 10, 20, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 0, 20, 10, 10);
    // shared edge on x, on y: zero-width overlap
    send_boxes(0, 0, 10, 10, 10, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 0, 10, 10, 10);
    // zero union: coincident points, far-apart points, overlapping lines
    send_boxes(5, 5, 0, 0, 5, 5, 0, 0);
    send_boxes(0, 0, 0, 0, 100, 100, 0, 0);
    send_boxes(0, 0, 0, 50, 0, 0, 0, 70);
    send_boxes(16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF);
    // A has no area, B does: ratio 0 but not degenerate
    send_boxes(0, 0, 10, 0, 1000, 1000, 20, 20);
    // nested quarter, partial overlap, one-pixel in a 2x2
    send_boxes(0, 0, 100, 100, 25, 25, 50, 50);
    send_boxes(0, 0, 10, 10, 5, 5, 10, 10);
    send_boxes(3, 7, 1, 1, 3, 7, 2, 2);
    // full-size boxes one pixel apart: union is 65535 * 65536
    send_boxes(0, 0, 16'hFFFF, 16'hFFFF, 1, 0, 16'hFFFF, 16'hFFFF);
    send_boxes(0, 0, 16'hFFFF, 16'hFFFF, 40000, 40000, 16'hFFFF, 16'hFFFF);
    // corner contact with edges past the coordinate range, both orders
    send_boxes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF);
    send_boxes(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_boxes(16'hFFFE, 16'hFFFE, 1, 1, 16'hFFFF, 16'hFFFF, 1, 1);
    // thin cross: one pixel shared, union of two long strips
    send_boxes(0, 0, 16'hFFFF, 1, 0, 0, 1, 16'hFFFF);

    drain_results();

    for (int i = 0; i < RandomPairs; i++) begin
      // every hundred pairs, maybe switch to a stretch at full rate
      if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == RandomPairs / 2) drain_results();
      send_pair(make_pair());
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    if (sb.fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Generous hard stop: the slowest legal run needs well under a millisecond.
  initial begin : watchdog
    #10ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/bor_pkg.sv
rtl/bor_geom.sv
rtl/bor_div.sv
rtl/box_overlap_ratio.sv
tb/tb_top.sv
